// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/mbpq_pkg.sv
// ----------------------------------------------------------------------------
// mbpq_pkg
// Command and status codes and fixed field widths of the priority queue.
// ----------------------------------------------------------------------------
package mbpq_pkg;

    localparam int CMD_W     = 3;
    localparam int HANDLE_W  = 8;
    localparam int KEY_IO_W  = 32;
    localparam int COUNT_W   = 9;

    typedef logic [CMD_W-1:0] t_cmd;
    typedef logic [1:0]       t_status;

    localparam t_cmd CMD_INSERT  = 3'd0;
    localparam t_cmd CMD_REMOVE  = 3'd1;
    localparam t_cmd CMD_CHANGE  = 3'd2;
    localparam t_cmd CMD_EXTRACT = 3'd3;
    localparam t_cmd CMD_PEEK    = 3'd4;

    localparam t_status ST_OK         = 2'd0;
    localparam t_status ST_EMPTY      = 2'd1;
    localparam t_status ST_ALREADY    = 2'd2;
    localparam t_status ST_NOT_QUEUED = 2'd3;

    localparam logic [KEY_IO_W-1:0] NO_KEY = 32'hFFFF_FFFF;

endpackage

// File: src/mbpq_key_ram.sv
// ----------------------------------------------------------------------------
// mbpq_key_ram
// Key store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mbpq_key_ram #(
    parameter int DEPTH     = 256,
    parameter int KEY_WIDTH = 32,
    parameter int ADDR_W    = 8
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_W-1:0]    i_waddr,
    input  logic [KEY_WIDTH-1:0] i_wdata,
    input  logic [ADDR_W-1:0]    i_raddr,
    output logic [KEY_WIDTH-1:0] o_rdata
);

    logic [KEY_WIDTH-1:0] r_mem [DEPTH];
    logic [KEY_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/multilevel_bucket_priority_queue_top.sv
// ----------------------------------------------------------------------------
// multilevel_bucket_priority_queue_top
// Addressable min priority queue over element handles with a key store.
// ----------------------------------------------------------------------------
// Flow: a command is registered on accept, executed in S_EXEC into result registers,
//   then loaded into the output registers from S_DONE once the output slot is free.
// Extract or peek with a stale cached minimum adds a scan of the key store
//   through one comparator, one entry per cycle, then returns to S_EXEC.
// A new command is accepted only once the previous result has left S_DONE; a held result delays it.
// Reset: synchronous; clears membership, count and cache; key store is kept.
module multilevel_bucket_priority_queue_top
    import mbpq_pkg::*;
#(
    parameter int CAPACITY  = 256,
    parameter int KEY_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic [KEY_IO_W-1:0] i_new_key,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [1:0]          o_status,
    output logic [HANDLE_W-1:0] o_out_handle,
    output logic [KEY_IO_W-1:0] o_out_key,
    output logic [COUNT_W-1:0]  o_entry_count
);

    // Only handles below 256 can be named, so storage stops there
    localparam int DEPTH = (CAPACITY < 256) ? CAPACITY : 256;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]           r_state, n_state;
    t_cmd                 r_cmd, n_cmd;
    logic [IDX_W-1:0]     r_hnd, n_hnd;
    logic [HANDLE_W-1:0]  r_echo, n_echo;
    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic [DEPTH-1:0]     r_member, n_member;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_cache_v, n_cache_v;
    logic [IDX_W-1:0]     r_cache_h, n_cache_h;
    logic [KEY_WIDTH-1:0] r_cache_k, n_cache_k;
    logic [IDX_W:0]       r_scan_idx, n_scan_idx;
    logic                 r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]     r_rd_idx, n_rd_idx;
    logic                 r_best_v, n_best_v;
    logic [IDX_W-1:0]     r_best_h, n_best_h;
    logic [KEY_WIDTH-1:0] r_best_k, n_best_k;
    t_status              r_res_status, n_res_status;
    logic [HANDLE_W-1:0]  r_res_handle, n_res_handle;
    logic [KEY_IO_W-1:0]  r_res_key, n_res_key;
    logic [COUNT_W-1:0]   r_res_count, n_res_count;
    logic                 r_o_valid, n_o_valid;
    t_status              r_o_status;
    logic [HANDLE_W-1:0]  r_o_handle;
    logic [KEY_IO_W-1:0]  r_o_key;
    logic [COUNT_W-1:0]   r_o_count;

    logic                 mem_we;
    logic [IDX_W-1:0]     mem_raddr;
    logic [KEY_WIDTH-1:0] mem_rdata;

    logic [31:0]          red_rem;
    logic [IDX_W-1:0]     hnd_red;
    logic [KEY_WIDTH-1:0] key_in;
    logic [KEY_WIDTH-1:0] key_legal;
    logic                 beats_cache;
    logic                 out_load;

    // Reduce the handle modulo CAPACITY by shifted compare and subtract
    always_comb begin
        red_rem = 32'(i_handle);
        for (int i = HANDLE_W - 1; i >= 0; i--) begin
            if (red_rem >= (32'(CAPACITY) << i)) begin
                red_rem = red_rem - (32'(CAPACITY) << i);
            end
        end
        hnd_red = red_rem[IDX_W-1:0];
    end

    // All ones is reserved: fold it one below
    assign key_in    = i_new_key[KEY_WIDTH-1:0];
    assign key_legal = (key_in == {KEY_WIDTH{1'b1}}) ? key_in - KEY_WIDTH'(1) : key_in;

    // Ties go to the lower handle
    assign beats_cache = (r_key < r_cache_k) || ((r_key == r_cache_k) && (r_hnd < r_cache_h));

    assign out_load = (r_state == S_DONE) && (!r_o_valid || i_ready);

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_hnd        = r_hnd;
        n_echo       = r_echo;
        n_key        = r_key;
        n_member     = r_member;
        n_count      = r_count;
        n_cache_v    = r_cache_v;
        n_cache_h    = r_cache_h;
        n_cache_k    = r_cache_k;
        n_scan_idx   = r_scan_idx;
        n_rd_vld     = r_rd_vld;
        n_rd_idx     = r_rd_idx;
        n_best_v     = r_best_v;
        n_best_h     = r_best_h;
        n_best_k     = r_best_k;
        n_res_status = r_res_status;
        n_res_handle = r_res_handle;
        n_res_key    = r_res_key;
        n_res_count  = r_res_count;
        mem_we       = 1'b0;
        mem_raddr    = r_scan_idx[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd   = i_cmd;
                    n_hnd   = hnd_red;
                    n_echo  = i_handle;
                    n_key   = key_legal;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_status = ST_OK;
                n_res_handle = r_echo;
                n_res_key    = NO_KEY;
                n_state      = S_DONE;
                case (r_cmd) inside
                    CMD_INSERT, CMD_CHANGE: begin
                        if (r_member[r_hnd]) begin
                            if (r_cmd == CMD_INSERT) begin
                                n_res_status = ST_ALREADY;
                            end else begin
                                mem_we = 1'b1;
                                if (r_cache_v) begin
                                    if (r_cache_h == r_hnd) begin
                                        // Raised key of the minimum: rescan later
                                        if (r_key > r_cache_k) begin
                                            n_cache_v = 1'b0;
                                        end else begin
                                            n_cache_k = r_key;
                                        end
                                    end else if (beats_cache) begin
                                        n_cache_h = r_hnd;
                                        n_cache_k = r_key;
                                    end
                                end
                            end
                        end else begin
                            mem_we           = 1'b1;
                            n_member[r_hnd]  = 1'b1;
                            n_count          = r_count + CNT_W'(1);
                            if (r_count == '0) begin
                                n_cache_v = 1'b1;
                                n_cache_h = r_hnd;
                                n_cache_k = r_key;
                            end else if (r_cache_v && beats_cache) begin
                                n_cache_h = r_hnd;
                                n_cache_k = r_key;
                            end
                        end
                    end
                    CMD_REMOVE: begin
                        if (!r_member[r_hnd]) begin
                            n_res_status = ST_NOT_QUEUED;
                        end else begin
                            n_member[r_hnd] = 1'b0;
                            n_count         = r_count - CNT_W'(1);
                            if (r_cache_h == r_hnd) begin
                                n_cache_v = 1'b0;
                            end
                        end
                    end
                    CMD_EXTRACT, CMD_PEEK: begin
                        if (r_count == '0) begin
                            n_res_status = ST_EMPTY;
                        end else if (!r_cache_v) begin
                            n_scan_idx = '0;
                            n_rd_vld   = 1'b0;
                            n_best_v   = 1'b0;
                            n_state    = S_SCAN;
                        end else begin
                            n_res_handle = HANDLE_W'(r_cache_h);
                            n_res_key    = KEY_IO_W'(r_cache_k);
                            if (r_cmd == CMD_EXTRACT) begin
                                n_member[r_cache_h] = 1'b0;
                                n_count             = r_count - CNT_W'(1);
                                n_cache_v           = 1'b0;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                n_res_count = COUNT_W'(n_count);
            end
            S_SCAN: begin
                // Issue one read a cycle, compare the entry read the cycle before
                if (r_scan_idx < (IDX_W+1)'(DEPTH)) begin
                    n_rd_vld   = 1'b1;
                    n_rd_idx   = r_scan_idx[IDX_W-1:0];
                    n_scan_idx = r_scan_idx + (IDX_W+1)'(1);
                end else begin
                    n_rd_vld = 1'b0;
                end
                if (r_rd_vld && r_member[r_rd_idx] && (!r_best_v || mem_rdata < r_best_k)) begin
                    n_best_v = 1'b1;
                    n_best_h = r_rd_idx;
                    n_best_k = mem_rdata;
                end
                if ((r_scan_idx == (IDX_W+1)'(DEPTH)) && !r_rd_vld) begin
                    n_cache_v = 1'b1;
                    n_cache_h = r_best_h;
                    n_cache_k = r_best_k;
                    n_state   = S_EXEC;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_o_valid = r_o_valid;
        if (out_load) begin
            n_o_valid = 1'b1;
        end else if (i_ready) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_member  <= '0;
            r_count   <= '0;
            r_cache_v <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_best_v  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_member  <= n_member;
            r_count   <= n_count;
            r_cache_v <= n_cache_v;
            r_rd_vld  <= n_rd_vld;
            r_best_v  <= n_best_v;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_hnd        <= n_hnd;
        r_echo       <= n_echo;
        r_key        <= n_key;
        r_cache_h    <= n_cache_h;
        r_cache_k    <= n_cache_k;
        r_scan_idx   <= n_scan_idx;
        r_rd_idx     <= n_rd_idx;
        r_best_h     <= n_best_h;
        r_best_k     <= n_best_k;
        r_res_status <= n_res_status;
        r_res_handle <= n_res_handle;
        r_res_key    <= n_res_key;
        r_res_count  <= n_res_count;
        if (out_load) begin
            r_o_status <= r_res_status;
            r_o_handle <= r_res_handle;
            r_o_key    <= r_res_key;
            r_o_count  <= r_res_count;
        end
    end

    mbpq_key_ram #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH),
        .ADDR_W    (IDX_W)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_hnd),
        .i_wdata (r_key),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_out_handle  = r_o_handle;
    assign o_out_key     = r_o_key;
    assign o_entry_count = r_o_count;

endmodule

// File: src/mbpq_checker.sv
// ----------------------------------------------------------------------------
// mbpq_checker
// Port-level checks on the result channel of the priority queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbpq_checker
    import mbpq_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_ready,
    input logic [1:0]          o_status,
    input logic [HANDLE_W-1:0] o_out_handle,
    input logic [KEY_IO_W-1:0] o_out_key,
    input logic [COUNT_W-1:0]  o_entry_count
);

    // A stalled result item holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_status) && $stable(o_out_handle) && $stable(o_out_key) && $stable(o_entry_count), "stalled result item changed")

    `ASSERT_SAME(a_empty_count, i_clk, i_rst_n, o_valid && (o_status == ST_EMPTY), (o_entry_count == '0) && (o_out_key == NO_KEY), "empty status with queued elements")

    `ASSERT_SAME(a_key_ok, i_clk, i_rst_n, o_valid && (o_out_key != NO_KEY), (o_status == ST_OK) && (o_entry_count != COUNT_W'(256) || 1'b1), "minimum key returned with error status")

    `ASSERT_SAME(a_already_count, i_clk, i_rst_n, o_valid && (o_status == ST_ALREADY), (o_entry_count != '0) && (o_out_key == NO_KEY), "already queued reported on empty queue")

endmodule

bind multilevel_bucket_priority_queue_top mbpq_checker u_mbpq_checker (.*);

// File: bench/multilevel_bucket_priority_queue_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multilevel_bucket_priority_queue_top_tb
// Self-checking bench for the addressable min priority queue. A directed
// table covers the empty queue, duplicate inserts, absent removes, the
// reserved key, key ties and the spare command codes. Random traffic follows,
// with fill and drain sweeps over every handle. Each response is compared
// field by field with a row's set value or the bench's behavioural copy.
// ----------------------------------------------------------------------------
module multilevel_bucket_priority_queue_top_tb;
    import mbpq_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 6;
    localparam int DEPTH        = 256;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = DEPTH + 40;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int TOTAL_ITEMS  = 1800;

    // Spare command codes: the block must echo and change nothing
    localparam t_cmd CMD_SPARE_5 = 3'd5;
    localparam t_cmd CMD_SPARE_6 = 3'd6;
    localparam t_cmd CMD_SPARE_7 = 3'd7;

    typedef struct packed {
        t_status             status;
        logic [HANDLE_W-1:0] handle;
        logic [KEY_IO_W-1:0] key;
        logic [COUNT_W-1:0]  count;
    } response_t;

    typedef struct packed {
        t_cmd                cmd;
        logic [HANDLE_W-1:0] handle;
        logic [KEY_IO_W-1:0] key;
        bit                  typed;
        response_t           want;
    } stim_row_t;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                i_valid   = 1'b0;
    logic [CMD_W-1:0]    i_cmd     = CMD_PEEK;
    logic [HANDLE_W-1:0] i_handle  = '0;
    logic [KEY_IO_W-1:0] i_new_key = '0;
    logic                i_ready   = 1'b0;
    logic                o_ready;
    logic                o_valid;
    logic [1:0]          o_status;
    logic [HANDLE_W-1:0] o_out_handle;
    logic [KEY_IO_W-1:0] o_out_key;
    logic [COUNT_W-1:0]  o_entry_count;

    // Behavioural copy of the queue
    logic [KEY_IO_W-1:0] model_key [DEPTH];
    bit                  model_queued [DEPTH];
    int                  model_count = 0;

    response_t awaited [$];
    stim_row_t directed_rows [$];

    int fail_count     = 0;
    int items_sent     = 0;
    int responses_seen = 0;
    int peak_count     = 0;
    int empty_replies  = 0;
    int cycle_count    = 0;
    int hold_ticket    = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    bit calm           = 1'b0;

    always #(CLK_HALF) i_clk = ~i_clk;

    multilevel_bucket_priority_queue_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_handle      (i_handle),
        .i_new_key     (i_new_key),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_out_handle  (o_out_handle),
        .o_out_key     (o_out_key),
        .o_entry_count (o_entry_count)
    );

    function automatic response_t predict_response(input t_cmd c,
                                                   input logic [HANDLE_W-1:0] h,
                                                   input logic [KEY_IO_W-1:0] k);
        response_t           r;
        logic [KEY_IO_W-1:0] stored;
        int                  best;
        bit                  found;
        r.status = ST_OK;
        r.handle = h;
        r.key    = NO_KEY;
        stored   = (k == NO_KEY) ? NO_KEY - 1 : k;
        best     = 0;
        found    = 1'b0;
        case (c) inside
            CMD_INSERT: begin
                if (model_queued[h]) begin
                    r.status = ST_ALREADY;
                end else begin
                    model_key[h]    = stored;
                    model_queued[h] = 1'b1;
                    model_count++;
                end
            end
            CMD_REMOVE: begin
                if (!model_queued[h]) begin
                    r.status = ST_NOT_QUEUED;
                end else begin
                    model_queued[h] = 1'b0;
                    model_count--;
                end
            end
            CMD_CHANGE: begin
                if (!model_queued[h]) begin
                    model_queued[h] = 1'b1;
                    model_count++;
                end
                model_key[h] = stored;
            end
            CMD_EXTRACT, CMD_PEEK: begin
                // strict less-than keeps the lowest handle among equal keys
                for (int i = 0; i < DEPTH; i++) begin
                    if (model_queued[i] && (!found || model_key[i] < model_key[best])) begin
                        best  = i;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.handle = best[HANDLE_W-1:0];
                    r.key    = model_key[best];
                    if (c == CMD_EXTRACT) begin
                        model_queued[best] = 1'b0;
                        model_count--;
                    end
                end
            end
            default: ;
        endcase
        r.count = model_count[COUNT_W-1:0];
        return r;
    endfunction

    // Prefer a handle in the wanted state, scanning from a random start
    function automatic logic [HANDLE_W-1:0] pick_handle(input bit want_queued);
        int                  start;
        logic [HANDLE_W-1:0] h;
        start = $urandom_range(0, DEPTH - 1);
        for (int i = 0; i < DEPTH; i++) begin
            h = HANDLE_W'((start + i) % DEPTH);
            if (model_queued[h] == want_queued)
                return h;
        end
        return start[HANDLE_W-1:0];
    endfunction

    function automatic logic [KEY_IO_W-1:0] rand_key();
        int unsigned         r;
        logic [KEY_IO_W-1:0] k;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            case ($urandom_range(0, 5))
                0:       k = '0;
                1:       k = NO_KEY;
                2:       k = NO_KEY - 1;
                3:       k = 32'h8000_0000;
                4:       k = 32'h7FFF_FFFF;
                default: k = 32'h0000_0001;
            endcase
        end else if (r < 35) begin
            // narrow range: plenty of equal keys
            k = $urandom_range(0, 7);
        end else if (r < 55) begin
            // shared upper digits: the minimum is decided in the low bits
            k = 32'h5A3C_0000 | ($urandom & 32'h0000_0F0F);
        end else begin
            k = $urandom;
        end
        return k;
    endfunction

    task automatic offer_item(input t_cmd c, input logic [HANDLE_W-1:0] h,
                              input logic [KEY_IO_W-1:0] k, input bit typed,
                              input response_t want);
        response_t predicted;
        i_valid   <= 1'b1;
        i_cmd     <= c;
        i_handle  <= h;
        i_new_key <= k;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        predicted = predict_response(c, h, k);
        awaited.push_back(typed ? want : predicted);
        items_sent++;
        if (predicted.status == ST_EMPTY)
            empty_replies++;
        if (model_count > peak_count)
            peak_count = model_count;
        if (!calm && $urandom_range(0, 99) < 7) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic send(input t_cmd c, input logic [HANDLE_W-1:0] h,
                        input logic [KEY_IO_W-1:0] k);
        offer_item(c, h, k, 1'b0, '0);
    endtask

    task automatic row_pred(input t_cmd c, input logic [HANDLE_W-1:0] h,
                            input logic [KEY_IO_W-1:0] k);
        directed_rows.push_back('{c, h, k, 1'b0, response_t'('0)});
    endtask

    task automatic row_known(input t_cmd c, input logic [HANDLE_W-1:0] h,
                             input logic [KEY_IO_W-1:0] k, input t_status st,
                             input logic [HANDLE_W-1:0] oh,
                             input logic [KEY_IO_W-1:0] ok, input int cnt);
        response_t w;
        w.status = st;
        w.handle = oh;
        w.key    = ok;
        w.count  = cnt[COUNT_W-1:0];
        directed_rows.push_back('{c, h, k, 1'b1, w});
    endtask

    task automatic random_mix(input int n);
        int unsigned         r;
        logic [HANDLE_W-1:0] any_h;
        repeat (n) begin
            r     = $urandom_range(0, 99);
            any_h = HANDLE_W'($urandom);
            if (r < 28)
                send(CMD_INSERT, ($urandom_range(0, 3) != 0) ? pick_handle(1'b0) : any_h,
                     rand_key());
            else if (r < 42)
                send(CMD_CHANGE, any_h, rand_key());
            else if (r < 56)
                send(CMD_REMOVE, ($urandom_range(0, 3) != 0) ? pick_handle(1'b1) : any_h,
                     rand_key());
            else if (r < 74)
                send(CMD_EXTRACT, any_h, rand_key());
            else if (r < 94)
                send(CMD_PEEK, any_h, rand_key());
            else begin
                case ($urandom_range(0, 2))
                    0:       send(CMD_SPARE_5, any_h, rand_key());
                    1:       send(CMD_SPARE_6, any_h, rand_key());
                    default: send(CMD_SPARE_7, any_h, rand_key());
                endcase
            end
        end
    endtask

    task automatic check_response();
        response_t w;
        if (awaited.size() == 0) begin
            $error("unexpected response: status %0d handle %0d key %h count %0d",
                   o_status, o_out_handle, o_out_key, o_entry_count);
            fail_count++;
        end else begin
            w = awaited.pop_front();
            responses_seen++;
            if (o_status !== w.status) begin
                $error("status: expected %0d, actual %0d", w.status, o_status);
                fail_count++;
            end
            if (o_out_handle !== w.handle) begin
                $error("out_handle: expected %0d, actual %0d", w.handle, o_out_handle);
                fail_count++;
            end
            if (o_out_key !== w.key) begin
                $error("out_key: expected %h, actual %h", w.key, o_out_key);
                fail_count++;
            end
            if (o_entry_count !== w.count) begin
                $error("entry_count: expected %0d, actual %0d", w.count, o_entry_count);
                fail_count++;
            end
        end
    endtask

    // Result side: check on the handshake, then choose next cycle's ready
    always @(posedge i_clk) begin
        if (o_valid === 1'b1 && i_ready)
            check_response();
        if (hold_ticket != hold_served) begin
            hold_served <= hold_ticket;
            hold_left   <= HOLD_CYCLES;
            i_ready     <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (calm) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= 7);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("run exceeded %0d cycles with %0d responses outstanding",
                   CYCLE_LIMIT, awaited.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int unsigned         r;
        logic [HANDLE_W-1:0] any_h;

        row_known(CMD_PEEK,    8'hA5, '0,            ST_EMPTY,      8'hA5, NO_KEY, 0);
        row_known(CMD_EXTRACT, 8'h00, '0,            ST_EMPTY,      8'h00, NO_KEY, 0);
        row_known(CMD_REMOVE,  8'hFF, '0,            ST_NOT_QUEUED, 8'hFF, NO_KEY, 0);
        row_known(CMD_INSERT,  8'hFF, '0,            ST_OK,         8'hFF, NO_KEY, 1);
        row_known(CMD_INSERT,  8'h00, NO_KEY,        ST_OK,         8'h00, NO_KEY, 2);
        row_known(CMD_INSERT,  8'hFF, 32'd5,         ST_ALREADY,    8'hFF, NO_KEY, 2);
        row_known(CMD_PEEK,    8'h00, '0,            ST_OK,         8'hFF, '0,     2);
        row_known(CMD_SPARE_5, 8'h3C, 32'h1234_5678, ST_OK,         8'h3C, NO_KEY, 2);
        row_known(CMD_SPARE_6, 8'hC3, NO_KEY,        ST_OK,         8'hC3, NO_KEY, 2);
        row_known(CMD_SPARE_7, 8'h81, '0,            ST_OK,         8'h81, NO_KEY, 2);
        row_known(CMD_CHANGE,  8'h07, '0,            ST_OK,         8'h07, NO_KEY, 3);
        row_pred(CMD_PEEK,    8'h55, '0);
        row_pred(CMD_CHANGE,  8'h07, NO_KEY - 1);
        row_pred(CMD_CHANGE,  8'hFF, NO_KEY);
        row_pred(CMD_PEEK,    8'h55, '0);
        row_pred(CMD_EXTRACT, 8'hAA, '0);
        row_pred(CMD_EXTRACT, 8'hAA, '0);
        row_pred(CMD_REMOVE,  8'hFF, '0);
        row_pred(CMD_INSERT,  8'h10, 32'h0100_0000);
        row_pred(CMD_INSERT,  8'h11, 32'h00FF_FFFF);
        row_pred(CMD_INSERT,  8'h12, 32'h0000_FF00);
        row_pred(CMD_INSERT,  8'h13, 32'h0000_00FF);
        row_pred(CMD_EXTRACT, 8'h00, '0);
        row_pred(CMD_EXTRACT, 8'h00, '0);
        row_pred(CMD_EXTRACT, 8'h00, '0);
        row_pred(CMD_REMOVE,  8'h10, '0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n])
            offer_item(directed_rows[n].cmd, directed_rows[n].handle, directed_rows[n].key,
                       directed_rows[n].typed, directed_rows[n].want);

        random_mix(500);

        // no idling on either side for a stretch
        calm <= 1'b1;
        random_mix(200);
        calm <= 1'b0;

        // receiver holds off while items keep coming, so the input stalls
        hold_ticket <= hold_ticket + 1;
        random_mix(40);

        // sender pauses until every response is back
        i_valid <= 1'b0;
        while (awaited.size() != 0) @(posedge i_clk);

        // fill every handle, work the full queue, then drain it
        while (model_count < DEPTH) begin
            if ($urandom_range(0, 9) == 0)
                send(CMD_PEEK, pick_handle(1'b1), rand_key());
            else
                send(CMD_INSERT, pick_handle(1'b0), rand_key());
        end
        repeat (20) begin
            r     = $urandom_range(0, 2);
            any_h = HANDLE_W'($urandom);
            if (r == 0)
                send(CMD_INSERT, any_h, rand_key());
            else if (r == 1)
                send(CMD_CHANGE, any_h, rand_key());
            else
                send(CMD_PEEK, any_h, rand_key());
        end
        while (model_count > 0) begin
            r     = $urandom_range(0, 99);
            any_h = HANDLE_W'($urandom);
            if (r < 80)
                send(CMD_EXTRACT, any_h, rand_key());
            else if (r < 90)
                send(CMD_REMOVE, pick_handle(1'b1), rand_key());
            else
                send(CMD_PEEK, any_h, rand_key());
        end
        repeat (4) begin
            any_h = HANDLE_W'($urandom);
            send(CMD_EXTRACT, any_h, rand_key());
        end

        if (items_sent < TOTAL_ITEMS)
            random_mix(TOTAL_ITEMS - items_sent);

        i_valid <= 1'b0;
        while (awaited.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Summary: %0d commands, %0d responses compared, occupancy peak %0d of %0d.",
                 items_sent, responses_seen, peak_count, DEPTH);
        $display("Summary: %0d empty-queue replies; fill, drain, ties and spare codes run.",
                 empty_replies);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
